// ----- rtl/tdl_pkg.sv -----
`timescale 1ns / 1ps
package tdl_pkg;

  typedef enum logic [2:0] {
    M_SLEEP     = 3'd0,
    M_BATTERY   = 3'd1,
    M_RAMP_UP   = 3'd2,
    M_HOLD      = 3'd3,
    M_READING   = 3'd4,
    M_RAMP_DOWN = 3'd5,
    M_ZERO      = 3'd6,
    M_FADING    = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    EYE_OFF    = 3'd0,
    EYE_RED    = 3'd1,
    EYE_YELLOW = 3'd2,
    EYE_GREEN  = 3'd3,
    EYE_CYAN   = 3'd4,
    EYE_BLUE   = 3'd5
  } eye_e;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_PRESS   = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    REG_WAKE     = 3'd0,
    REG_BATTERY  = 3'd1,
    REG_DISPLAY  = 3'd2,
    REG_INACT    = 3'd3,
    REG_FADE     = 3'd4,
    REG_RAMP     = 3'd5
  } reg_e;

  typedef enum logic [1:0] {
    C_IDLE,
    C_MUL,
    C_DIV,
    C_OUT
  } ctl_e;

  // controller -> datapath commands
  typedef struct packed {
    logic load;      // take the input item and run the mode rules
    logic div_start; // register the fade product and start the divide
    logic div_step;  // one divide iteration
    logic div_done;  // write quotient into brightness
  } cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic need_div;
    logic div_last;
  } sts_t;

  localparam int BLINK_LAST = 3499;
  localparam int FLASH_LAST = 999;
  localparam int BLINK_RED  = 150;
  localparam int FLASH_ON   = 500;
  localparam int BAT_LOW    = 10;

  function automatic logic [2:0] bars_of(input logic [6:0] v);
    if (v >= 7'd81) return 3'd4;
    if (v >= 7'd61) return 3'd3;
    if (v >= 7'd41) return 3'd2;
    if (v >= 7'd21) return 3'd1;
    return 3'd0;
  endfunction

endpackage

// ----- rtl/touch_dimmer_lamp_controller.sv -----
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// in       in_valid / in_stall   req_type_i, battery_percent_i, charging_i
// out      out_valid / out_stall lamp_level_o .. lightning_icon_o
// cfg      cfg_we_i              cfg_idx_i, cfg_data_i
// An item passes through accept, rule check and result. While fading, the
// one-bit-per-cycle fade divider runs between the rule check and the result.
// One item at a time: in_stall is high from acceptance until the result is taken.
// Reset is asynchronous; all registers but the battery, charging and divider payload ones reset at once.
// A stalled result holds; the next item is taken the cycle after it leaves.
module touch_dimmer_lamp_controller import tdl_pkg::*; #(
  parameter int LEVEL_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  battery_percent_i,
  input  logic        charging_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] lamp_level_o,
  output logic [2:0]  mode_code_o,
  output logic        digits_on_o,
  output logic [6:0]  shown_value_o,
  output logic [2:0]  bar_count_o,
  output logic [2:0]  eye_color_o,
  output logic        percent_icon_o,
  output logic        lightning_icon_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  tdl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall, .out_valid, .out_stall,
    .cmd_o(cmd), .sts_i(sts)
  );

  tdl_datapath #(.LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i, .battery_percent_i, .charging_i,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .lamp_level_o, .mode_code_o, .digits_on_o, .shown_value_o, .bar_count_o,
    .eye_color_o, .percent_icon_o, .lightning_icon_o
  );

  // no input taken while a result waits
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> in_stall) else $error("input taken while result pending");

  // an accepted item leads to no result in the very next cycle
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !in_stall) |=> !out_valid) else $error("result too early");

  // sleep without digits lights no bars
  a_sleep_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && mode_code_o == M_SLEEP && !digits_on_o) |-> (bar_count_o == 3'd0))
    else $error("bars lit in sleep");

endmodule

// ----- rtl/tdl_ctrl.sv -----
`timescale 1ns / 1ps
module tdl_ctrl import tdl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd_o,
  input  sts_t sts_i
);

  ctl_e state_q, state_d;

  // hold the state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequence load, product, divide, output
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_q)
      C_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = C_MUL;
        end
      end
      C_MUL: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = C_DIV;
        end else begin
          state_d = C_OUT;
        end
      end
      C_DIV: begin
        if (sts_i.div_last) begin
          cmd_o.div_done = 1'b1;
          state_d        = C_OUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      C_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_d = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

endmodule

// ----- rtl/tdl_datapath.sv -----
`timescale 1ns / 1ps
module tdl_datapath import tdl_pkg::*; #(
  parameter int LEVEL_FRAC_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output sts_t        sts_o,
  input  logic [1:0]  req_type_i,
  input  logic [6:0]  battery_percent_i,
  input  logic        charging_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [21:0] cfg_data_i,
  output logic [14:0] lamp_level_o,
  output logic [2:0]  mode_code_o,
  output logic        digits_on_o,
  output logic [6:0]  shown_value_o,
  output logic [2:0]  bar_count_o,
  output logic [2:0]  eye_color_o,
  output logic        percent_icon_o,
  output logic        lightning_icon_o
);

  localparam int LW = 7 + LEVEL_FRAC_BITS;
  localparam logic [LW-1:0] ONE  = LW'(1) << LEVEL_FRAC_BITS;
  localparam logic [LW-1:0] FULL = LW'(100) << LEVEL_FRAC_BITS;
  localparam int PW = LW + 18;
  localparam int CW = $clog2(PW);
  localparam logic [CW-1:0] DIV_LAST = CW'(PW - 1);

  logic [15:0] wake_q, bshow_q, doff_q;
  logic [21:0] inact_q;
  logic [17:0] fade_q;
  logic [7:0]  rstep_q;

  mode_e mode_q, mode_d;
  logic [LW-1:0] lamp_q, lamp_d, saved_q, saved_d, fstart_q, fstart_d;
  logic held_q, held_d;
  logic [15:0] press_q, press_d, phase_q, phase_d;
  logic [7:0]  ramp_q, ramp_d;
  logic [21:0] read_q, read_d;
  logic [17:0] fel_q, fel_d;
  logic [11:0] blink_q, blink_d;
  logic [9:0]  flash_q, flash_d;
  logic need_div_d, need_div_q;
  logic [6:0] bp_q;
  logic chg_q;

  // divider: restoring, one quotient bit per cycle
  logic [PW-1:0] num_q;
  logic [18:0]   rem_q;
  logic [CW-1:0] cnt_q;
  logic [18:0]   rem_sh;
  logic [PW-1:0] prod_d;

  // write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_q  <= 16'd1500;
      bshow_q <= 16'd5000;
      doff_q  <= 16'd3000;
      inact_q <= 22'd900000;
      fade_q  <= 18'd60000;
      rstep_q <= 8'd25;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_WAKE:    wake_q  <= cfg_data_i[15:0];
        REG_BATTERY: bshow_q <= cfg_data_i[15:0];
        REG_DISPLAY: doff_q  <= cfg_data_i[15:0];
        REG_INACT:   inact_q <= cfg_data_i;
        REG_FADE:    fade_q  <= cfg_data_i[17:0];
        REG_RAMP:    rstep_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // run handler and mode rules for one item
  always_comb begin
    logic [7:0] step;
    logic [LW:0] up;
    step = (rstep_q == 8'd0) ? 8'd1 : rstep_q;
    mode_d = mode_q; lamp_d = lamp_q; saved_d = saved_q; fstart_d = fstart_q;
    held_d = held_q; press_d = press_q; phase_d = phase_q; ramp_d = ramp_q;
    read_d = read_q; fel_d = fel_q; blink_d = blink_q; flash_d = flash_q;
    need_div_d = 1'b0;
    up = '0;
    case (req_e'(req_type_i))
      REQ_TICK: begin
        if (press_d != 16'hFFFF) press_d = press_d + 16'd1;
        if (phase_d != 16'hFFFF) phase_d = phase_d + 16'd1;
        if (ramp_d != 8'hFF) ramp_d = ramp_d + 8'd1;
        if (read_d != 22'h3FFFFF) read_d = read_d + 22'd1;
        if (fel_d != 18'h3FFFF) fel_d = fel_d + 18'd1;
        blink_d = (blink_d >= 12'(BLINK_LAST)) ? 12'd0 : blink_d + 12'd1;
        flash_d = (flash_d >= 10'(FLASH_LAST)) ? 10'd0 : flash_d + 10'd1;
      end
      REQ_PRESS: begin
        press_d = '0; held_d = 1'b1;
        if (mode_d == M_FADING) begin
          mode_d = M_READING; lamp_d = saved_d; read_d = '0;
        end else if (mode_d == M_BATTERY) begin
          mode_d = M_RAMP_UP; lamp_d = '0; ramp_d = '0;
        end else if (mode_d == M_READING || mode_d == M_HOLD) begin
          mode_d = M_RAMP_DOWN; ramp_d = '0;
        end
      end
      REQ_RELEASE: begin
        held_d = 1'b0;
        if (mode_d == M_RAMP_UP || mode_d == M_RAMP_DOWN) begin
          if (lamp_d != '0) begin
            saved_d = lamp_d; mode_d = M_HOLD; phase_d = '0;
          end else if (mode_d == M_RAMP_UP) begin
            mode_d = M_SLEEP;
          end else begin
            mode_d = M_ZERO; phase_d = '0;
          end
        end
      end
      default: ;
    endcase
    if (mode_d == M_SLEEP && held_d && press_d >= wake_q) begin
      mode_d = M_BATTERY; phase_d = '0; lamp_d = '0;
    end
    if (mode_d == M_BATTERY && !held_d && phase_d >= bshow_q) mode_d = M_SLEEP;
    if (mode_d == M_RAMP_UP && held_d && ramp_d >= step) begin
      ramp_d = '0;
      if (lamp_d < FULL) begin
        up = {1'b0, lamp_d} + {1'b0, ONE};
        lamp_d = (up > {1'b0, FULL}) ? FULL : up[LW-1:0];
      end
    end
    if (mode_d == M_HOLD && phase_d >= doff_q) begin
      mode_d = M_READING; read_d = '0;
    end
    if (mode_d == M_RAMP_DOWN && held_d && ramp_d >= step) begin
      ramp_d = '0;
      lamp_d = (lamp_d > ONE) ? lamp_d - ONE : '0;
    end
    if (mode_d == M_ZERO && phase_d >= doff_q) begin
      mode_d = M_SLEEP; lamp_d = '0;
    end
    if (mode_d == M_READING && read_d >= inact_q) begin
      mode_d = M_FADING; fel_d = '0; fstart_d = lamp_d;
    end
    if (mode_d == M_FADING) begin
      if (fel_d >= fade_q) begin
        lamp_d = '0; mode_d = M_SLEEP;
      end else begin
        need_div_d = 1'b1;
      end
    end
  end

  // form the fade product from the registered state
  assign prod_d = PW'(fstart_q) * PW'(fade_q - fel_q);

  assign rem_sh = {rem_q[17:0], num_q[PW-1]};

  // hold state and step the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= M_SLEEP; lamp_q <= '0; saved_q <= LW'(70) << LEVEL_FRAC_BITS;
      fstart_q <= '0; held_q <= 1'b0; press_q <= '0; phase_q <= '0;
      ramp_q <= '0; read_q <= '0; fel_q <= '0; blink_q <= '0; flash_q <= '0;
      need_div_q <= 1'b0; cnt_q <= '0;
    end else if (cmd_i.load) begin
      mode_q <= mode_d; lamp_q <= lamp_d; saved_q <= saved_d;
      fstart_q <= fstart_d; held_q <= held_d; press_q <= press_d;
      phase_q <= phase_d; ramp_q <= ramp_d; read_q <= read_d; fel_q <= fel_d;
      blink_q <= blink_d; flash_q <= flash_d; need_div_q <= need_div_d;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + CW'(1);
    end else if (cmd_i.div_done) begin
      lamp_q <= {num_q[LW-2:0], (rem_sh >= {1'b0, fade_q})};
      need_div_q <= 1'b0;
    end
  end

  // divider payload and the battery and charging inputs
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bp_q  <= (battery_percent_i > 7'd100) ? 7'd100 : battery_percent_i;
      chg_q <= charging_i;
    end else if (cmd_i.div_start) begin
      num_q <= prod_d;
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      if (rem_sh >= {1'b0, fade_q}) begin
        rem_q <= rem_sh - {1'b0, fade_q};
        num_q <= {num_q[PW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        num_q <= {num_q[PW-2:0], 1'b0};
      end
    end
  end

  assign sts_o.need_div = need_div_q;
  assign sts_o.div_last = (cnt_q == DIV_LAST);

  // build display fields
  always_comb begin
    logic [LW:0] rnd;
    logic [6:0] r;
    rnd = {1'b0, lamp_q} + (LW+1)'(ONE >> 1);
    r = (rnd[LW:LEVEL_FRAC_BITS] > 8'd100) ? 7'd100 : rnd[LEVEL_FRAC_BITS+6:LEVEL_FRAC_BITS];
    digits_on_o = 1'b0; shown_value_o = '0; bar_count_o = '0;
    eye_color_o = EYE_OFF; percent_icon_o = 1'b0; lightning_icon_o = 1'b0;
    if (chg_q) begin
      digits_on_o = 1'b1; shown_value_o = bp_q; bar_count_o = bars_of(bp_q);
      percent_icon_o = 1'b1;
      lightning_icon_o = (flash_q >= 10'(FLASH_ON));
      eye_color_o = (bp_q >= 7'd100) ? EYE_BLUE : EYE_CYAN;
    end else if (mode_q == M_SLEEP) begin
      eye_color_o = EYE_OFF;
    end else if (mode_q == M_READING || mode_q == M_FADING) begin
      if (bp_q < 7'(BAT_LOW) && blink_q < 12'(BLINK_RED)) eye_color_o = EYE_RED;
    end else if (mode_q == M_BATTERY) begin
      digits_on_o = 1'b1; shown_value_o = bp_q; bar_count_o = bars_of(bp_q);
      percent_icon_o = 1'b1;
      if (bp_q >= 7'd100) eye_color_o = EYE_BLUE;
      else if (bp_q >= 7'd67) eye_color_o = EYE_GREEN;
      else if (bp_q >= 7'd34) eye_color_o = EYE_YELLOW;
      else eye_color_o = EYE_RED;
    end else begin
      digits_on_o = 1'b1; shown_value_o = r; bar_count_o = bars_of(r);
      percent_icon_o = 1'b1;
      eye_color_o = (mode_q == M_ZERO) ? EYE_RED : EYE_CYAN;
    end
  end

  assign mode_code_o = mode_q;

  // convert to Q7.8
  generate
    if (LEVEL_FRAC_BITS >= 8) begin : g_shr
      assign lamp_level_o = 15'(lamp_q >> (LEVEL_FRAC_BITS - 8));
    end else begin : g_shl
      assign lamp_level_o = 15'({lamp_q, (8 - LEVEL_FRAC_BITS)'(0)});
    end
  endgenerate

endmodule
